// File: rtl/core/wrl_pkg.sv
// ----------------------------------------------------------------------------
// wrl_pkg: shared types and constants of the wakeup-to-run latency tracker
// Holds the table entry layout, the table write request and the reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package wrl_pkg;

  localparam int TABLE_ENTRIES_DEF = 256;
  localparam int TABLE_ENTRIES_MAX = 16384;
  localparam logic [31:0] MIN_DELAY_RST = 32'd100000;

  localparam logic OP_WAKE   = 1'b0;
  localparam logic OP_SWITCH = 1'b1;

  typedef struct packed {
    logic        valid;
    logic [31:0] key;
    logic [63:0] stamp;
  } tbl_entry_t;

  typedef struct packed {
    logic       we;
    tbl_entry_t data;
  } tbl_wr_t;

endpackage

`default_nettype wire

// File: rtl/core/wakeup_to_run_latency_tracker.sv
// ----------------------------------------------------------------------------
// wakeup_to_run_latency_tracker: wakeup-to-run latency tracker, top level
// Records wakeup times per task id and reports the wait at switch-in when it is at least min_delay_ns.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake            Payload
// in_      input      in_valid / in_stall  op, task_id, now_ns, running_thread_id
// out_     output     out_valid/out_stall  measured_task, reporting_thread,
//                                          switch_time_ns, delay_ns
// cfg_     input      cfg_we               min_delay_ns (cfg_wdata)
//
// A wakeup or switch-in is paced by the scan of the table through its single
// read port and key compare. After reset the table is cleared with in_stall
// high. A result sits in the output register; the next transaction is taken
// meanwhile and only a second result waits for out_stall to drop.
// ----------------------------------------------------------------------------
`default_nettype none

module wakeup_to_run_latency_tracker #(
  parameter int TABLE_ENTRIES = wrl_pkg::TABLE_ENTRIES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_op,
  input  wire logic [31:0] in_task_id,
  input  wire logic [63:0] in_now_ns,
  input  wire logic [31:0] in_running_thread_id,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      out_measured_task,
  output logic [31:0]      out_reporting_thread,
  output logic [63:0]      out_switch_time_ns,
  output logic [63:0]      out_delay_ns,
  input  wire logic        cfg_we,
  input  wire logic [31:0] cfg_wdata
);
  import wrl_pkg::*;

  localparam int AW = $clog2(TABLE_ENTRIES);

  tbl_wr_t       tbl_wr;
  logic [AW-1:0] tbl_waddr;
  logic [AW-1:0] tbl_raddr;
  tbl_entry_t    tbl_rdata;

  wrl_table #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_table (
    .clk   (clk),
    .wr    (tbl_wr),
    .waddr (tbl_waddr),
    .raddr (tbl_raddr),
    .rdata (tbl_rdata)
  );

  wrl_ctrl #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_ctrl (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_op                (in_op),
    .in_task_id           (in_task_id),
    .in_now_ns            (in_now_ns),
    .in_running_thread_id (in_running_thread_id),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_measured_task    (out_measured_task),
    .out_reporting_thread (out_reporting_thread),
    .out_switch_time_ns   (out_switch_time_ns),
    .out_delay_ns         (out_delay_ns),
    .cfg_we               (cfg_we),
    .cfg_wdata            (cfg_wdata),
    .tbl_wr               (tbl_wr),
    .tbl_waddr            (tbl_waddr),
    .tbl_raddr            (tbl_raddr),
    .tbl_rdata            (tbl_rdata)
  );

endmodule

`default_nettype wire

// File: rtl/core/wrl_table.sv
// ----------------------------------------------------------------------------
// wrl_table: task table storage
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module wrl_table #(
  parameter int TABLE_ENTRIES = wrl_pkg::TABLE_ENTRIES_DEF,
  localparam int AW = $clog2(TABLE_ENTRIES)
) (
  input  wire logic                clk,
  input  wire wrl_pkg::tbl_wr_t    wr,
  input  wire logic [AW-1:0]       waddr,
  input  wire logic [AW-1:0]       raddr,
  output wrl_pkg::tbl_entry_t      rdata
);
  import wrl_pkg::*;

  tbl_entry_t mem [TABLE_ENTRIES];

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[waddr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: rtl/core/wrl_ctrl.sv
// ----------------------------------------------------------------------------
// wrl_ctrl: sequencer of the latency tracker
// Clears the table after reset, scans it once per transaction with one key
// comparator, updates the hit or free slot and computes the delay.
// ----------------------------------------------------------------------------
`default_nettype none

module wrl_ctrl #(
  parameter int TABLE_ENTRIES = wrl_pkg::TABLE_ENTRIES_DEF,
  localparam int AW = $clog2(TABLE_ENTRIES),
  localparam int CW = $clog2(TABLE_ENTRIES + 1)
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic                in_op,
  input  wire logic [31:0]         in_task_id,
  input  wire logic [63:0]         in_now_ns,
  input  wire logic [31:0]         in_running_thread_id,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [31:0]              out_measured_task,
  output logic [31:0]              out_reporting_thread,
  output logic [63:0]              out_switch_time_ns,
  output logic [63:0]              out_delay_ns,
  input  wire logic                cfg_we,
  input  wire logic [31:0]         cfg_wdata,
  output wrl_pkg::tbl_wr_t         tbl_wr,
  output logic [AW-1:0]            tbl_waddr,
  output logic [AW-1:0]            tbl_raddr,
  input  wire wrl_pkg::tbl_entry_t tbl_rdata
);
  import wrl_pkg::*;

  typedef enum logic [6:0] {
    ST_CLEAR  = 7'b0000001,
    ST_IDLE   = 7'b0000010,
    ST_SCAN   = 7'b0000100,
    ST_UPDATE = 7'b0001000,
    ST_DIFF   = 7'b0010000,
    ST_CHECK  = 7'b0100000,
    ST_EMIT   = 7'b1000000
  } state_t;

  state_t        state_r, state_nxt;
  logic [AW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [CW-1:0] rd_cnt_r, rd_cnt_nxt;
  logic          pend_r, pend_nxt;
  logic [AW-1:0] pend_idx_r, pend_idx_nxt;
  logic          hit_r, hit_nxt;
  logic [AW-1:0] hit_idx_r, hit_idx_nxt;
  logic          free_r, free_nxt;
  logic [AW-1:0] free_idx_r, free_idx_nxt;
  logic [63:0]   stamp_r, stamp_nxt;
  logic [63:0]   delay_r, delay_nxt;
  logic [31:0]   min_delay_r;
  logic          op_r;
  logic [31:0]   id_r;
  logic [63:0]   now_r;
  logic [31:0]   thread_r;
  logic          out_valid_r, out_valid_nxt;
  logic          in_accept;
  logic          issue;
  logic          out_load;
  logic          key_match;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && (state_r == ST_IDLE);
  assign issue     = (rd_cnt_r != CW'(TABLE_ENTRIES));
  assign tbl_raddr = rd_cnt_r[AW-1:0];
  assign key_match = tbl_rdata.valid && (tbl_rdata.key == id_r);
  assign out_load  = (state_r == ST_EMIT) && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    rd_cnt_nxt    = rd_cnt_r;
    pend_nxt      = 1'b0;
    pend_idx_nxt  = pend_idx_r;
    hit_nxt       = hit_r;
    hit_idx_nxt   = hit_idx_r;
    free_nxt      = free_r;
    free_idx_nxt  = free_idx_r;
    stamp_nxt     = stamp_r;
    delay_nxt     = delay_r;
    tbl_wr.we     = 1'b0;
    tbl_wr.data   = '{valid: 1'b0, key: id_r, stamp: now_r};
    tbl_waddr     = clr_cnt_r;
    out_valid_nxt = out_load || (out_valid_r && out_stall);
    case (state_r)
      ST_CLEAR: begin
        tbl_wr.we   = 1'b1;
        clr_cnt_nxt = clr_cnt_r + AW'(1);
        if (clr_cnt_r == AW'(TABLE_ENTRIES - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_accept) begin
          rd_cnt_nxt = '0;
          hit_nxt    = 1'b0;
          free_nxt   = 1'b0;
          state_nxt  = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (issue) begin
          rd_cnt_nxt   = rd_cnt_r + CW'(1);
          pend_nxt     = 1'b1;
          pend_idx_nxt = rd_cnt_r[AW-1:0];
        end
        if (pend_r) begin
          if (key_match && !hit_r) begin
            hit_nxt     = 1'b1;
            hit_idx_nxt = pend_idx_r;
            stamp_nxt   = tbl_rdata.stamp;
          end
          if (!tbl_rdata.valid && !free_r) begin
            free_nxt     = 1'b1;
            free_idx_nxt = pend_idx_r;
          end
        end
        if (!issue && !pend_r) begin
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        state_nxt = ST_IDLE;
        if (op_r == OP_WAKE) begin
          tbl_wr.data.valid = 1'b1;
          tbl_wr.we         = hit_r || free_r;
          tbl_waddr         = hit_r ? hit_idx_r : free_idx_r;
        end else if (hit_r) begin
          tbl_wr.we = 1'b1;
          tbl_waddr = hit_idx_r;
          state_nxt = ST_DIFF;
        end
      end
      ST_DIFF: begin
        delay_nxt = now_r - stamp_r;
        state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        state_nxt = (delay_r >= {32'd0, min_delay_r}) ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      rd_cnt_r    <= '0;
      pend_r      <= 1'b0;
      hit_r       <= 1'b0;
      free_r      <= 1'b0;
      out_valid_r <= 1'b0;
      min_delay_r <= MIN_DELAY_RST;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      rd_cnt_r    <= rd_cnt_nxt;
      pend_r      <= pend_nxt;
      hit_r       <= hit_nxt;
      free_r      <= free_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        min_delay_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_idx_r <= pend_idx_nxt;
    hit_idx_r  <= hit_idx_nxt;
    free_idx_r <= free_idx_nxt;
    stamp_r    <= stamp_nxt;
    delay_r    <= delay_nxt;
    if (in_accept) begin
      op_r     <= in_op;
      id_r     <= in_task_id;
      now_r    <= in_now_ns;
      thread_r <= in_running_thread_id;
    end
    if (out_load) begin
      out_measured_task    <= id_r;
      out_reporting_thread <= thread_r;
      out_switch_time_ns   <= now_r;
      out_delay_ns         <= delay_r;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/wrl_checker.sv
// ----------------------------------------------------------------------------
// wrl_checker: port-level checks of the latency tracker
// Watches the channels of the top level and is bound to it.
// ----------------------------------------------------------------------------
`default_nettype none

module wrl_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [63:0] out_delay_ns
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_delay_ns))
    else $error("stalled result changed");

  a_clear_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(rst_n) |-> in_stall)
    else $error("transaction taken during table clear");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("transaction taken while table scan runs");

endmodule

bind wakeup_to_run_latency_tracker wrl_checker u_wrl_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .out_delay_ns (out_delay_ns)
);

`default_nettype wire
